/* rtl/core/svgf_pkg.sv */
`timescale 1ns / 1ps

package svgf_pkg;

    // fixed widths of the port fields
    localparam int RANGE_W     = 16;
    localparam int THRESH_W    = 20;
    localparam int MARGIN_W    = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = THRESH_W;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // register indexes on the configuration port
    localparam cfg_index_t CFG_VAR_THRESHOLD = cfg_index_t'(0);
    localparam cfg_index_t CFG_JUMP_MARGIN   = cfg_index_t'(1);

    // reset values: 0.01 m^2 and 0.1 m
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10000);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(100);

endpackage

/* rtl/core/sonar_variance_gate_filter.sv */
`timescale 1ns / 1ps

// Variance-gated outlier filter for sonar range samples. Each sample beat is
// shifted into a window of the last WINDOW_LEN samples; running sum and sum of
// squares are kept up to date at acceptance, so the window variance is tested
// exactly as N*sum(x^2) - (sum x)^2 < N*(N-1)*variance_threshold. A steady
// window makes the new sample the valid range; otherwise the sample is taken
// only if it lies strictly within jump_margin of the last range taken from a
// steady window. Until the window is full, samples are stored and the held
// range is reported with window_full and sample_accepted low. The block takes
// one sample per cycle while out_ready does not hold it back: the window/sum
// stage loads with the sample, then a multiply stage, a compare stage and the
// decision stage that owns the range state and the result register. Exactly
// one result beat per sample. Configuration is to be written through cfg_*
// only while idle (the block does not enforce this); cfg_ready is always high.
module sonar_variance_gate_filter
    import svgf_pkg::*;
#(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [RANGE_W-1:0]     range_sample,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RANGE_W-1:0]     filtered_range,
    output logic                   window_full,
    output logic                   sample_accepted
);

    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int SQ_W       = 2 * SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int VAR_W      = 2 * SUM_W;
    localparam int PAIR_COUNT = WINDOW_LEN * (WINDOW_LEN - 1);
    localparam int THR_TERM_W = THRESH_W + $clog2(PAIR_COUNT + 1);
    localparam int CMP_W      = (VAR_W > THR_TERM_W) ? VAR_W : THR_TERM_W;
    localparam int DIST_W     = (SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W;

    // configuration
    logic [THRESH_W-1:0]    thresh_reg;
    logic [MARGIN_W-1:0]    margin_reg;

    // window state
    logic [SAMPLE_BITS-1:0] window_reg [WINDOW_LEN];
    logic [FILL_W-1:0]      fill_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]        sumsq_reg;

    // stage 1
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_full_reg;

    // stage 2
    logic                   s2_valid_reg;
    logic [SAMPLE_BITS-1:0] s2_sample_reg;
    logic                   s2_full_reg;
    logic [CMP_W-1:0]       sum_sq_reg;
    logic [CMP_W-1:0]       n_sumsq_reg;
    logic [CMP_W-1:0]       thr_term_reg;

    // stage 3
    logic                   s3_valid_reg;
    logic [SAMPLE_BITS-1:0] s3_sample_reg;
    logic                   s3_full_reg;
    logic                   steady_reg;

    // decision stage and result register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] valid_range_reg;
    logic [SAMPLE_BITS-1:0] last_valid_reg;
    logic                   window_full_reg;
    logic                   accepted_reg;

    logic                   out_adv;
    logic                   s3_ready;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   in_fire;

    logic [SAMPLE_BITS-1:0] in_sample;
    logic [2*SAMPLE_BITS-1:0] new_sq;
    logic [2*SAMPLE_BITS-1:0] old_sq;
    logic [SUM_W-1:0]       sum_next;
    logic [SQ_W-1:0]        sumsq_next;
    logic [FILL_W-1:0]      fill_next;

    logic [SAMPLE_BITS-1:0] jump_dist;
    logic                   near;
    logic [SAMPLE_BITS-1:0] valid_range_next;
    logic [SAMPLE_BITS-1:0] last_valid_next;
    logic                   accepted_next;

    // ready chain lets bubbles collapse
    assign out_adv  = !out_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || out_adv;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign in_fire  = in_valid && s1_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VAR_THRESHOLD: thresh_reg <= cfg_data;
                CFG_JUMP_MARGIN:   margin_reg <= cfg_data[MARGIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // stage 1: shift window, update running sums
    always_comb
    begin
        in_sample  = SAMPLE_BITS'(range_sample);
        new_sq     = (2*SAMPLE_BITS)'(in_sample) * (2*SAMPLE_BITS)'(in_sample);
        old_sq     = (2*SAMPLE_BITS)'(window_reg[0]) * (2*SAMPLE_BITS)'(window_reg[0]);
        sum_next   = sum_reg + SUM_W'(in_sample) - SUM_W'(window_reg[0]);
        sumsq_next = sumsq_reg + SQ_W'(new_sq) - SQ_W'(old_sq);
        if (fill_reg < FILL_W'(WINDOW_LEN))
            fill_next = fill_reg + FILL_W'(1);
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                window_reg[i] <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else if (in_fire)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
                window_reg[i] <= window_reg[i+1];
            window_reg[WINDOW_LEN-1] <= in_sample;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= in_sample;
            s1_full_reg   <= (fill_next == FILL_W'(WINDOW_LEN));
        end
    end

    // stage 2: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_full_reg   <= s1_full_reg;
            sum_sq_reg    <= CMP_W'(sum_reg) * CMP_W'(sum_reg);
            n_sumsq_reg   <= CMP_W'(sumsq_reg) * CMP_W'(WINDOW_LEN);
            thr_term_reg  <= CMP_W'(thresh_reg) * CMP_W'(PAIR_COUNT);
        end
    end

    // stage 3: variance test, n*sumsq never falls below sum^2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ready)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_sample_reg <= s2_sample_reg;
            s3_full_reg   <= s2_full_reg;
            steady_reg    <= (n_sumsq_reg - sum_sq_reg) < thr_term_reg;
        end
    end

    // decision stage
    always_comb
    begin
        if (last_valid_reg > s3_sample_reg)
            jump_dist = last_valid_reg - s3_sample_reg;
        else
            jump_dist = s3_sample_reg - last_valid_reg;
        near = DIST_W'(jump_dist) < DIST_W'(margin_reg);

        valid_range_next = valid_range_reg;
        last_valid_next  = last_valid_reg;
        accepted_next    = 1'b0;
        if (s3_full_reg)
        begin
            if (steady_reg)
            begin
                valid_range_next = s3_sample_reg;
                last_valid_next  = s3_sample_reg;
                accepted_next    = 1'b1;
            end
            else if (near)
            begin
                valid_range_next = s3_sample_reg;
                accepted_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            valid_range_reg <= '0;
            last_valid_reg  <= '0;
            window_full_reg <= 1'b0;
            accepted_reg    <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                valid_range_reg <= valid_range_next;
                last_valid_reg  <= last_valid_next;
                window_full_reg <= s3_full_reg;
                accepted_reg    <= accepted_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_range  = RANGE_W'(valid_range_reg);
    assign window_full     = window_full_reg;
    assign sample_accepted = accepted_reg;

endmodule
